// ===== hdl/oge_pkg.sv =====
`default_nettype none
package oge_pkg;

  localparam int unsigned SumW   = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DvdW   = 44;
  localparam int unsigned AlphaW = 26;
  localparam int unsigned PW     = 30;
  localparam int unsigned QDepth = 2;

  localparam logic [GainW-1:0] CeilingReset = 16'd40960;
  localparam logic [GainW-1:0] BoostReset   = 16'd4506;
  localparam logic [29:0]      PLimit       = 30'd8192;

  typedef enum logic {
    REG_CEILING = 1'b0,
    REG_BOOST   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_SQ1,
    ST_SQ2,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic [2:0][SumW-1:0] ref_sum;
    logic [2:0][SumW-1:0] tgt_sum;
  } sums_t;

  // Elaboration-time table entry: largest x with x^4 <= 255^3 * v * 2^32.
  function automatic logic [15:0] bright_val(input int unsigned v);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] q;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [16:0] mid;
    n  = (64'd16581375 * 64'(v)) << 32;
    lo = 17'd0;
    hi = 17'd65535;
    for (int i = 0; i < 17; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 17'd1) >> 1);
        m   = 64'(mid);
        q   = (m * m) * (m * m);
        if (q <= n) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    return lo[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/oge_front.sv =====
`default_nettype none
module oge_front #(
  parameter int unsigned MaxSlicePixels = 65536
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   ref_red_i,
  input  wire logic [7:0]   ref_green_i,
  input  wire logic [7:0]   ref_blue_i,
  input  wire logic [7:0]   tgt_red_i,
  input  wire logic [7:0]   tgt_green_i,
  input  wire logic [7:0]   tgt_blue_i,
  input  wire logic         slice_end_i,
  output logic              push_o,
  output oge_pkg::sums_t    push_data_o,
  input  wire logic         full_i
);
  import oge_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSlicePixels + 1);

  logic [15:0] rom [256];
  for (genvar v = 0; v < 256; v++) begin : g_rom
    localparam logic [15:0] Val = bright_val(v);
    assign rom[v] = Val;
  end

  sums_t         sums_q, sums_d, added;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          accept, add_en;
  logic [2:0][7:0] rpix, tpix;

  assign rpix = {ref_blue_i, ref_green_i, ref_red_i};
  assign tpix = {tgt_blue_i, tgt_green_i, tgt_red_i};
  assign in_ready_o = !full_i;
  assign accept = in_valid_i && in_ready_o;
  assign add_en = cnt_q < CntW'(MaxSlicePixels);

  always_comb begin
    added = sums_q;
    if (add_en) begin
      for (int c = 0; c < 3; c++) begin
        added.ref_sum[c] = sums_q.ref_sum[c] + SumW'(rom[rpix[c]]);
        added.tgt_sum[c] = sums_q.tgt_sum[c] + SumW'(rom[tpix[c]]);
      end
    end
  end

  always_comb begin
    sums_d = sums_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (slice_end_i) begin
        sums_d = '0;
        cnt_d  = '0;
      end else begin
        sums_d = added;
        if (add_en) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  assign push_o      = accept && slice_end_i;
  assign push_data_o = added;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      cnt_q  <= '0;
    end else begin
      sums_q <= sums_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/oge_queue.sv =====
`default_nettype none
module oge_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  oge_pkg::sums_t  push_data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output oge_pkg::sums_t  pop_data_o
);
  import oge_pkg::*;

  sums_t      mem_q [QDepth];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'(QDepth);
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/oge_back.sv =====
`default_nettype none
module oge_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  oge_pkg::sums_t    q_data_i,
  output logic              pop_o,
  input  wire logic [15:0]  ceiling_i,
  input  wire logic [15:0]  boost_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [15:0]       gain_red_o,
  output logic [15:0]       gain_green_o,
  output logic [15:0]       gain_blue_o
);
  import oge_pkg::*;

  back_state_e          state_q, state_d;
  sums_t                item_q;
  logic [1:0]           ch_q;
  logic [5:0]           bit_q;
  logic [DvdW-1:0]      dvd_q, quo_q;
  logic [SumW:0]        rem_q, rem_sh;
  logic [PW-1:0]        p_q;
  logic [13:0]          p2_q;
  logic [2:0][GainW-1:0] gain_q;
  logic [SumW-1:0]      r, t;
  logic [AlphaW-1:0]    alpha;
  logic                 t_zero, rem_ge;
  logic [15:0]          p4;

  assign r      = item_q.ref_sum[ch_q];
  assign t      = item_q.tgt_sum[ch_q];
  assign t_zero = t == '0;
  assign rem_sh = {rem_q[SumW-1:0], dvd_q[DvdW-1]};
  assign rem_ge = rem_sh >= {1'b0, t};
  assign alpha  = (|quo_q[DvdW-1:AlphaW]) ? '1 : quo_q[AlphaW-1:0];
  assign p4     = 16'((28'(p2_q) * 28'(p2_q)) >> 12);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = ST_START;
      ST_START: begin
        if (t_zero) begin
          state_d = (ch_q == 2'd2) ? ST_OUT : ST_START;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:   if (bit_q == 6'(DvdW - 1)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SQ1;
      ST_SQ1: begin
        if (p_q >= PLimit) begin
          state_d = (ch_q == 2'd2) ? ST_OUT : ST_START;
        end else begin
          state_d = ST_SQ2;
        end
      end
      ST_SQ2:   state_d = (ch_q == 2'd2) ? ST_OUT : ST_START;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: pop_o       = q_valid_i;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign gain_red_o   = gain_q[0];
  assign gain_green_o = gain_q[1];
  assign gain_blue_o  = gain_q[2];

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        item_q <= q_data_i;
        ch_q   <= 2'd0;
      end
      ST_START: begin
        if (t_zero) begin
          gain_q[ch_q] <= (r == '0) ? '0 : ceiling_i;
          ch_q         <= ch_q + 2'd1;
        end
        dvd_q <= DvdW'(({1'b0, r} + {1'b0, t}) << 11);
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, t} : rem_sh;
        quo_q <= {quo_q[DvdW-2:0], rem_ge};
        dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
        bit_q <= bit_q + 6'd1;
      end
      ST_MUL: p_q <= PW'((42'(alpha) * 42'(boost_i)) >> 12);
      ST_SQ1: begin
        if (p_q >= PLimit) begin
          gain_q[ch_q] <= ceiling_i;
          ch_q         <= ch_q + 2'd1;
        end
        p2_q <= 14'((26'(p_q[12:0]) * 26'(p_q[12:0])) >> 12);
      end
      ST_SQ2: begin
        gain_q[ch_q] <= (p4 > ceiling_i) ? ceiling_i : p4;
        ch_q         <= ch_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/overlap_gain_estimator.sv =====
// Pixel pairs are taken at one transfer per cycle until the two-entry slice queue is full.
// After a slice_end transfer is queued and popped, out_valid_o rises once each channel has
// passed a start step, a one-bit-per-cycle 44-step divider and three multiply steps.
// A zero target sum or a large alpha-times-boost product ends a channel early.
// The back end takes one slice at a time and pops the next only after the last result is taken.
// Reset clears the sums, the pixel count and the queue and loads the register defaults.
`default_nettype none
module overlap_gain_estimator #(
  parameter int unsigned MaxSlicePixels = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ref_red_i,
  input  wire logic [7:0]  ref_green_i,
  input  wire logic [7:0]  ref_blue_i,
  input  wire logic [7:0]  tgt_red_i,
  input  wire logic [7:0]  tgt_green_i,
  input  wire logic [7:0]  tgt_blue_i,
  input  wire logic        slice_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      gain_red_o,
  output logic [15:0]      gain_green_o,
  output logic [15:0]      gain_blue_o
);
  import oge_pkg::*;

  logic [15:0] ceiling_q, boost_q;
  logic        wr_en, push, full, pop, q_valid;
  sums_t       push_data, pop_data;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    case (idx)
      REG_CEILING: prdata = {16'd0, ceiling_q};
      REG_BOOST:   prdata = {16'd0, boost_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CeilingReset;
      boost_q   <= BoostReset;
    end else if (wr_en) begin
      case (idx)
        REG_CEILING: ceiling_q <= pwdata[15:0];
        REG_BOOST:   boost_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  oge_front #(
    .MaxSlicePixels(MaxSlicePixels)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .ref_red_i, .ref_green_i, .ref_blue_i,
    .tgt_red_i, .tgt_green_i, .tgt_blue_i, .slice_end_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  oge_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .pop_data_o(pop_data)
  );

  oge_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(pop_data), .pop_o(pop),
    .ceiling_i(ceiling_q), .boost_i(boost_q),
    .out_valid_o, .out_ready_i,
    .gain_red_o, .gain_green_o, .gain_blue_o
  );

endmodule
`default_nettype wire
